// File: rtl/mmpq_pkg.sv
// mmpq_pkg: sizes, function and status codes and sequencer states for the
// min/max priority queue core. No dependencies; used by every file but mmpq_ram.
package mmpq_pkg;

  // table depth and derived widths
  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths
  localparam int VAL_W  = 32;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 6;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [FUNC_W-1:0]       func_t;
  typedef logic [STAT_W-1:0]       status_t;
  typedef logic [OCC_W-1:0]        occ_t;

  // function codes
  localparam func_t FN_PUSH     = 2'd0;
  localparam func_t FN_POP_LOW  = 2'd1;
  localparam func_t FN_POP_HIGH = 2'd2;

  // status codes
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_SCAN,
    S_POP_SCAN,
    S_POP_LAST,
    S_FINISH
  } state_t;

endpackage

// File: rtl/mmpq_req_if.sv
// mmpq_req_if: request channel (valid/ready plus push/pop command).
// Depends on mmpq_pkg for field types.
interface mmpq_req_if;
  import mmpq_pkg::*;

  logic   valid;
  logic   ready;
  func_t  func;
  value_t push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink (input valid, input func, input push_value, output ready);
endinterface

// File: rtl/mmpq_rsp_if.sv
// mmpq_rsp_if: result channel (valid/ready plus popped value, status, occupancy).
// Depends on mmpq_pkg for field types.
interface mmpq_rsp_if;
  import mmpq_pkg::*;

  logic    valid;
  logic    ready;
  value_t  popped_value;
  status_t status;
  occ_t    occupancy;

  modport source (output valid, output popped_value, output status, output occupancy,
                  input ready);
  modport sink (input valid, input popped_value, input status, input occupancy,
                output ready);
endinterface

// File: rtl/mmpq_ram.sv
// mmpq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/min_max_priority_queue_core.sv
// min_max_priority_queue_core: double-ended priority queue top level.
// Depends on mmpq_pkg, mmpq_req_if, mmpq_rsp_if and mmpq_ram.
//
// Usage:
//   req carries one command per transfer: push a signed value, pop the lowest
//   or pop the highest stored value. rsp returns exactly one result per
//   command: the popped value (0 for push or empty), a status code and the
//   occupancy after the command.
//   Values live in a CAPACITY-entry RAM; valid marks and the count are flops.
//   A push walks the valid marks from slot 0, one slot a cycle, and writes
//   the first free slot, then moves on to the finish step.
//   A pop streams every slot through the RAM read port, one a cycle, into a
//   single compare unit that keeps the best value (ties keep the lower slot).
//   Full push, empty pop and unused codes go straight to the finish step.
//   req.ready is high only while idle: no new command is taken until the last one is done.
//   The result sits in an output register, so a new command is taken while a
//   previous result still waits; if the receiver stalls, the next result
//   waits in the finish step until the output register is free.
//   Reset (synchronous, active high) empties the queue at once; no clearing
//   pass is needed.
module min_max_priority_queue_core (
  input logic         clk,
  input logic         rst,
  mmpq_req_if.sink    req,
  mmpq_rsp_if.source  rsp
);
  import mmpq_pkg::*;

  state_t               state;
  state_t               state_next;
  func_t                op_func;
  value_t               op_value;
  logic [IDX_W-1:0]     scan_idx;
  logic [CAPACITY-1:0]  slot_valid;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_after;
  status_t              res_status;

  logic                 cmp_vld;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 best_have;
  logic [IDX_W-1:0]     best_idx;
  value_t               best_val;

  logic                 rsp_valid;
  value_t               rsp_value;
  status_t              rsp_status;
  occ_t                 rsp_occ;

  logic                 req_fire;
  logic                 slot_free;
  logic                 can_load;
  logic                 op_is_pop;
  logic                 pop_take;
  logic                 ram_wr_en;
  logic                 ram_rd_en;
  logic [VAL_W-1:0]     ram_rd_data;
  value_t               cand_val;
  logic                 better;
  logic                 take;

  // handshake and decode
  assign req.ready  = (state == S_IDLE);
  assign req_fire   = req.valid && req.ready;
  assign slot_free  = !slot_valid[scan_idx];
  assign can_load   = !rsp_valid || rsp.ready;
  assign op_is_pop  = (op_func == FN_POP_LOW) || (op_func == FN_POP_HIGH);
  assign pop_take   = op_is_pop && (res_status == ST_DONE);
  assign count_after = pop_take ? count - CNT_W'(1) : count;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req.func == FN_PUSH) begin
            state_next = (count == CNT_W'(CAPACITY)) ? S_FINISH : S_PUSH_SCAN;
          end else if (req.func == FN_POP_LOW || req.func == FN_POP_HIGH) begin
            state_next = (count == '0) ? S_FINISH : S_POP_SCAN;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_PUSH_SCAN: begin
        if (slot_free) begin
          state_next = S_FINISH;
        end
      end
      S_POP_SCAN: begin
        if (scan_idx == IDX_W'(CAPACITY - 1)) begin
          state_next = S_POP_LAST;
        end
      end
      S_POP_LAST: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (can_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // sequencer outputs: ram strobes
  always_comb begin
    ram_wr_en = 1'b0;
    ram_rd_en = 1'b0;
    unique case (state)
      S_PUSH_SCAN: ram_wr_en = slot_free;
      S_POP_SCAN:  ram_rd_en = 1'b1;
      default: begin
        ram_wr_en = 1'b0;
        ram_rd_en = 1'b0;
      end
    endcase
  end

  // value store
  mmpq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (scan_idx),
    .wr_data (op_value),
    .rd_en   (ram_rd_en),
    .rd_addr (scan_idx),
    .rd_data (ram_rd_data)
  );

  // shared compare unit
  assign cand_val = $signed(ram_rd_data);
  assign better   = (op_func == FN_POP_HIGH) ? (cand_val > best_val) : (cand_val < best_val);
  assign take     = cmp_vld && (!best_have || better);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command capture, scan counter, valid marks and count
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      count      <= '0;
      scan_idx   <= '0;
      res_status <= ST_DONE;
      op_func    <= FN_PUSH;
    end else begin
      if (req_fire) begin
        op_func    <= req.func;
        scan_idx   <= '0;
        res_status <= ST_DONE;
        if (req.func == FN_PUSH && count == CNT_W'(CAPACITY)) begin
          res_status <= ST_FULL;
        end else if ((req.func == FN_POP_LOW || req.func == FN_POP_HIGH) && count == '0) begin
          res_status <= ST_EMPTY;
        end
      end
      if (state == S_PUSH_SCAN) begin
        if (slot_free) begin
          slot_valid[scan_idx] <= 1'b1;
          count                <= count + CNT_W'(1);
        end else begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
      end
      if (state == S_POP_SCAN) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (state == S_FINISH && can_load && pop_take) begin
        slot_valid[best_idx] <= 1'b0;
        count                <= count - CNT_W'(1);
      end
    end
  end

  // push payload
  always_ff @(posedge clk) begin
    if (req_fire) begin
      op_value <= req.push_value;
    end
  end

  // compare pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld   <= 1'b0;
      best_have <= 1'b0;
    end else begin
      cmp_vld <= (state == S_POP_SCAN) && slot_valid[scan_idx];
      if (req_fire) begin
        best_have <= 1'b0;
      end else if (take) begin
        best_have <= 1'b1;
      end
    end
  end

  // compare pipeline payload
  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (take) begin
      best_val <= cand_val;
      best_idx <= cmp_idx;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_FINISH && can_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && can_load) begin
      rsp_value  <= pop_take ? best_val : '0;
      rsp_status <= res_status;
      rsp_occ    <= OCC_W'(count_after);
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.popped_value = rsp_value;
  assign rsp.status       = rsp_status;
  assign rsp.occupancy    = rsp_occ;

  // count never exceeds the table depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  // count tracks the valid marks
  a_count_marks: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) == int'(count))
    else $error("stored count disagrees with valid marks");

  // a successful pop always has a candidate from the scan
  a_pop_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && pop_take) |-> best_have && slot_valid[best_idx])
    else $error("pop finished without a valid candidate");

  // a push that starts scanning ends by filling a slot
  a_push_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH_SCAN && state_next == S_FINISH) |=> slot_valid[$past(scan_idx)])
    else $error("push scan finished without filling a slot");

endmodule
